/* src/secded_hamming_codec_unit_macros.svh */
`ifndef SECDED_HAMMING_CODEC_UNIT_MACROS_SVH
`define SECDED_HAMMING_CODEC_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SHC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("secded codec check failed");

// next-cycle implication, sampled on clk, off during reset
`define SHC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("secded codec check failed");

`endif

/* src/shc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package shc_pkg;

	localparam int DATA_W = 64;
	localparam int LEN_W  = 6;
	localparam int CNT_W  = 7;
	localparam int POS_W  = 6;

	localparam logic [LEN_W-1:0] MAX_DATA_BITS     = 6'd57;
	localparam logic [LEN_W-1:0] DATA_LENGTH_RESET = 6'd8;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_CORRECTED = 2'd1,
		ST_DOUBLE    = 2'd2
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [LEN_W-1:0]  k;
		logic [DATA_W-1:0] word;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] word;
		logic [CNT_W-1:0]  bits;
		status_t           status;
		logic [POS_W-1:0]  epos;
	} res_t;

endpackage

`default_nettype wire

/* src/secded_hamming_codec_unit.sv */
// SECDED extended Hamming encoder/decoder, one word per cycle while the response is not stalled.
// request channel: req_valid/req_stall with opcode, valid_bits, word_in;
//   a transfer happens on a rising edge with req_valid high and req_stall low.
// response channel: rsp_valid/rsp_stall with word_out, out_bits, status,
//   error_position; a transfer happens with rsp_valid high and rsp_stall low.
// config channel: cfg_valid/cfg_ready/cfg_data writes data_length; cfg_ready
//   is always high. write it only while no request is in flight.
// path: an accepted request is held in the input register, passes one pass of XOR
//   trees, and is held in the result register that drives the response ports.
// throughput: one word per cycle while the response is not stalled, set by the
//   single-pass datapath between the two registers.
// reset (arst_n low): both pipeline stages empty, data_length back to 8.
// stall: a stalled response holds; the input register keeps taking one more
//   word, and req_stall rises only when both stages are full and the
//   response is stalled.
`timescale 1ns / 1ps
`default_nettype none

module secded_hamming_codec_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [shc_pkg::LEN_W-1:0]    cfg_data,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic                         opcode,
	input  logic [shc_pkg::LEN_W-1:0]    valid_bits,
	input  logic [shc_pkg::DATA_W-1:0]   word_in,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [shc_pkg::DATA_W-1:0]   word_out,
	output logic [shc_pkg::CNT_W-1:0]    out_bits,
	output logic [1:0]                   status,
	output logic [shc_pkg::POS_W-1:0]    error_position
);
	import shc_pkg::*;

	function automatic logic [LEN_W-1:0] clamp_bits(input logic [LEN_W-1:0] v,
			input logic [LEN_W-1:0] dl);
		logic [LEN_W-1:0] lim;
		logic [LEN_W-1:0] r;
		lim = dl;
		if (lim == '0) begin
			lim = LEN_W'(1);
		end
		if (lim > MAX_DATA_BITS) begin
			lim = MAX_DATA_BITS;
		end
		r = v;
		if (r == '0) begin
			r = LEN_W'(1);
		end
		if (r > lim) begin
			r = lim;
		end
		return r;
	endfunction

	logic [LEN_W-1:0] data_length_q;
	logic             v_s1;
	logic             v_s2;
	req_t             req_s1;
	res_t             res_s2;
	res_t             res_c;
	logic             adv1;
	logic             adv2;

	assign cfg_ready = 1'b1;

	assign adv2      = !v_s2 || !rsp_stall;
	assign adv1      = !v_s1 || adv2;
	assign req_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_length_q <= DATA_LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			data_length_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= req_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && req_valid) begin
			req_s1.op   <= op_t'(opcode);
			req_s1.k    <= clamp_bits(valid_bits, data_length_q);
			req_s1.word <= word_in;
		end
		if (adv2 && v_s1) begin
			res_s2 <= res_c;
		end
	end

	shc_core u_core (
		.req (req_s1),
		.res (res_c)
	);

	assign rsp_valid      = v_s2;
	assign word_out       = res_s2.word;
	assign out_bits       = res_s2.bits;
	assign status         = res_s2.status;
	assign error_position = res_s2.epos;

endmodule

`default_nettype wire

/* src/shc_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module shc_core (
	input  shc_pkg::req_t req,
	output shc_pkg::res_t res
);
	import shc_pkg::*;

	function automatic logic [DATA_W-1:0] low_mask(input logic [CNT_W-1:0] n);
		logic [DATA_W-1:0] m;
		for (int i = 0; i < DATA_W; i++) begin
			m[i] = (CNT_W'(i) < n);
		end
		return m;
	endfunction

	function automatic logic [POS_W-1:0] syndrome(input logic [DATA_W-1:0] w);
		logic [POS_W-1:0] s;
		s = '0;
		for (int p = 0; p < DATA_W; p++) begin
			for (int b = 0; b < POS_W; b++) begin
				if (((p >> b) & 1) != 0) begin
					s[b] = s[b] ^ w[p];
				end
			end
		end
		return s;
	endfunction

	function automatic logic [CNT_W-1:0] code_length(input logic [LEN_W-1:0] k);
		logic [CNT_W-1:0] kk;
		kk = {1'b0, k};
		priority if (k <= LEN_W'(1)) begin
			return kk + CNT_W'(3);
		end else if (k <= LEN_W'(4)) begin
			return kk + CNT_W'(4);
		end else if (k <= LEN_W'(11)) begin
			return kk + CNT_W'(5);
		end else if (k <= LEN_W'(26)) begin
			return kk + CNT_W'(6);
		end else begin
			return kk + CNT_W'(7);
		end
	endfunction

	always_comb begin
		int                d;
		logic [CNT_W-1:0]  n;
		logic [DATA_W-1:0] dm;
		logic [DATA_W-1:0] cm;
		logic [DATA_W-1:0] cw;
		logic [DATA_W-1:0] enc;
		logic [DATA_W-1:0] dec;
		logic [POS_W-1:0]  syn;
		logic [POS_W-1:0]  syn_e;
		logic              par;
		status_t           st;
		logic [POS_W-1:0]  epos;

		n   = code_length(req.k);
		dm  = req.word & low_mask({1'b0, req.k});
		cm  = req.word & low_mask(n);
		syn = syndrome(cm);
		par = ^cm;

		st   = ST_OK;
		epos = '0;
		cw   = cm;
		priority if (par) begin
			priority if (syn == '0) begin
				st = ST_CORRECTED;
			end else if ({1'b0, syn} < n) begin
				st   = ST_CORRECTED;
				epos = syn;
				cw   = cm ^ (DATA_W'(1) << syn);
			end else begin
				st = ST_DOUBLE;
			end
		end else if (syn != '0) begin
			st = ST_DOUBLE;
		end

		// data bits sit at every nonzero position that is not a power of two
		enc = '0;
		dec = '0;
		d   = 0;
		for (int p = 3; p < DATA_W; p++) begin
			if ((p & (p - 1)) != 0) begin
				enc[p] = dm[d];
				dec[d] = cw[p];
				d++;
			end
		end

		syn_e = syndrome(enc);
		for (int i = 0; i < POS_W; i++) begin
			enc[1 << i] = syn_e[i];
		end
		enc[0] = ^enc[DATA_W-1:1];

		unique case (req.op)
			OP_ENCODE: begin
				res.word   = enc;
				res.bits   = n;
				res.status = ST_OK;
				res.epos   = '0;
			end
			OP_DECODE: begin
				res.word   = dec;
				res.bits   = {1'b0, req.k};
				res.status = st;
				res.epos   = epos;
			end
			default: begin
				res.word   = '0;
				res.bits   = '0;
				res.status = ST_OK;
				res.epos   = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/shc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "secded_hamming_codec_unit_macros.svh"

module shc_props (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_stall,
	input  logic                         rsp_valid,
	input  logic                         rsp_stall,
	input  logic [shc_pkg::DATA_W-1:0]   word_out,
	input  logic [shc_pkg::CNT_W-1:0]    out_bits,
	input  logic [1:0]                   status,
	input  logic [shc_pkg::POS_W-1:0]    error_position
);
	import shc_pkg::*;

	`SHC_ASSERT_NEXT(a_rsp_hold_valid, rsp_valid && rsp_stall, rsp_valid)
	`SHC_ASSERT_NEXT(a_rsp_hold_data, rsp_valid && rsp_stall,
		$stable(word_out) && $stable(out_bits) && $stable(status) && $stable(error_position))
	`SHC_ASSERT_NOW(a_stall_only_when_full, req_stall, rsp_valid && rsp_stall)
	`SHC_ASSERT_NOW(a_epos_only_on_fix, rsp_valid && (status != ST_CORRECTED),
		error_position == '0)

endmodule

bind secded_hamming_codec_unit shc_props u_shc_checker (.*);

`default_nettype wire

/* test/shc_checker.sv */
`timescale 1ns / 1ps

module shc_checker
	import shc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [LEN_W-1:0]  cfg_data,
	input  logic              req_valid,
	input  logic              req_stall,
	input  logic              opcode,
	input  logic [LEN_W-1:0]  valid_bits,
	input  logic [DATA_W-1:0] word_in,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  logic [DATA_W-1:0] word_out,
	input  logic [CNT_W-1:0]  out_bits,
	input  logic [1:0]        status,
	input  logic [POS_W-1:0]  error_position,
	output int                errors,
	output int                pending
);

	logic [LEN_W-1:0] len_reg;
	res_t             results_due[$];
	res_t             due;

	function automatic res_t hamming_result(input logic op, input logic [LEN_W-1:0] vb,
			input logic [DATA_W-1:0] w, input logic [LEN_W-1:0] dl);
		res_t              r;
		logic [DATA_W-1:0] cw;
		int                lim;
		int                k;
		int                np;
		int                n;
		int                d;
		int                syn;
		int                p;
		logic              par;
		lim = dl;
		if (lim < 1)
			lim = 1;
		if (lim > int'(MAX_DATA_BITS))
			lim = MAX_DATA_BITS;
		k = vb;
		if (k < 1)
			k = 1;
		if (k > lim)
			k = lim;
		np = 1;
		while ((1 << np) < k + np + 1)
			np++;
		n = k + np + 1;
		r = '0;
		r.status = ST_OK;
		syn = 0;
		par = 1'b0;
		d = 0;
		if (op == OP_ENCODE) begin
			for (p = 3; p < n; p++) begin
				if ((p & (p - 1)) != 0) begin
					if (w[d]) begin
						r.word[p] = 1'b1;
						syn ^= p;
					end
					d++;
				end
			end
			for (p = 1; p < n; p = p << 1) begin
				if ((syn & p) != 0)
					r.word[p] = 1'b1;
			end
			r.word[0] = ^r.word[DATA_W-1:1];
			r.bits = CNT_W'(n);
		end else begin
			cw = w;
			for (p = 0; p < n; p++) begin
				if (w[p]) begin
					par = ~par;
					syn ^= p;
				end
			end
			if (par) begin
				if (syn == 0) begin
					r.status = ST_CORRECTED;
				end else if (syn < n) begin
					r.status = ST_CORRECTED;
					r.epos = POS_W'(syn);
					cw[syn] = ~cw[syn];
				end else begin
					r.status = ST_DOUBLE;
				end
			end else if (syn != 0) begin
				r.status = ST_DOUBLE;
			end
			for (p = 3; p < n; p++) begin
				if ((p & (p - 1)) != 0) begin
					r.word[d] = cw[p];
					d++;
				end
			end
			r.bits = CNT_W'(k);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_due.delete();
			len_reg = DATA_LENGTH_RESET;
			errors = 0;
			pending = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (results_due.size() == 0) begin
					$error("response transfer with no result due");
					errors++;
				end else begin
					due = results_due.pop_front();
					if (word_out !== due.word) begin
						$error("word_out expected %h got %h", due.word, word_out);
						errors++;
					end
					if (out_bits !== due.bits) begin
						$error("out_bits expected %0d got %0d", due.bits, out_bits);
						errors++;
					end
					if (status !== due.status) begin
						$error("status expected %0d got %0d", due.status, status);
						errors++;
					end
					if (error_position !== due.epos) begin
						$error("error_position expected %0d got %0d", due.epos,
							error_position);
						errors++;
					end
				end
			end
			if (req_valid && !req_stall)
				results_due = {results_due,
					hamming_result(opcode, valid_bits, word_in, len_reg)};
			if (cfg_valid && cfg_ready)
				len_reg = cfg_data;
			pending = results_due.size();
		end
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
	import shc_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [LEN_W-1:0]  cfg_data;
	logic              req_valid;
	logic              req_stall;
	logic              opcode;
	logic [LEN_W-1:0]  valid_bits;
	logic [DATA_W-1:0] word_in;
	logic              rsp_valid;
	logic              rsp_stall;
	logic [DATA_W-1:0] word_out;
	logic [CNT_W-1:0]  out_bits;
	logic [1:0]        status;
	logic [POS_W-1:0]  error_position;

	int               errors;
	int               pending;
	int               src_idle;
	int               snk_idle;
	int               hold_wanted;
	int               holds_done;
	logic [LEN_W-1:0] cur_len;

	secded_hamming_codec_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.opcode         (opcode),
		.valid_bits     (valid_bits),
		.word_in        (word_in),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.word_out       (word_out),
		.out_bits       (out_bits),
		.status         (status),
		.error_position (error_position)
	);

	shc_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.opcode         (opcode),
		.valid_bits     (valid_bits),
		.word_in        (word_in),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.word_out       (word_out),
		.out_bits       (out_bits),
		.status         (status),
		.error_position (error_position),
		.errors         (errors),
		.pending        (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [DATA_W-1:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_word(input op_t op, input logic [LEN_W-1:0] vb,
			input logic [DATA_W-1:0] w);
		while ($urandom_range(99) < src_idle) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		opcode <= op;
		valid_bits <= vb;
		word_in <= w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_len = v;
	endtask

	// receiver side: random stall, plus long hold-offs on request
	initial begin
		rsp_stall = 1'b1;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (hold_wanted > holds_done) begin
				holds_done++;
				rsp_stall <= 1'b1;
				repeat (60) @(negedge clk);
			end else begin
				rsp_stall <= ($urandom_range(99) < snk_idle);
			end
		end
	end

	initial begin
		#3000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [DATA_W-1:0] ones;
		logic [DATA_W-1:0] data;
		logic [DATA_W-1:0] w;
		logic [LEN_W-1:0]  vb;
		logic [LEN_W-1:0]  lens[3][3];
		res_t              enc;
		int                sel;
		int                lim;
		int                n;
		int                p1;
		int                p2;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		req_valid = 1'b0;
		opcode = 1'b0;
		valid_bits = '0;
		word_in = '0;
		hold_wanted = 0;
		src_idle = 17;
		snk_idle = 65;
		cur_len = DATA_LENGTH_RESET;
		ones = '1;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset length, bit count clamping
		send_word(OP_ENCODE, 6'd8, ones);
		send_word(OP_ENCODE, 6'd0, ones);
		send_word(OP_ENCODE, 6'd63, ones);
		enc = u_chk.hamming_result(OP_ENCODE, 6'd8, 64'hA5, cur_len);
		send_word(OP_DECODE, 6'd8, enc.word);
		drain();
		write_length(MAX_DATA_BITS);

		// full-length words
		send_word(OP_ENCODE, MAX_DATA_BITS, '0);
		send_word(OP_ENCODE, MAX_DATA_BITS, ones);
		send_word(OP_ENCODE, MAX_DATA_BITS, 64'hAAAA_AAAA_AAAA_AAAA);
		enc = u_chk.hamming_result(OP_ENCODE, MAX_DATA_BITS, ones, cur_len);
		send_word(OP_DECODE, MAX_DATA_BITS, enc.word);
		send_word(OP_DECODE, MAX_DATA_BITS, enc.word ^ (64'd1 << 37));
		send_word(OP_DECODE, MAX_DATA_BITS, enc.word ^ (64'd1 << 16));
		send_word(OP_DECODE, MAX_DATA_BITS, enc.word ^ 64'd1);
		send_word(OP_DECODE, MAX_DATA_BITS, enc.word ^ (64'd1 << 5) ^ (64'd1 << 60));
		send_word(OP_DECODE, MAX_DATA_BITS, enc.word ^ (64'd1 << 63));
		send_word(OP_DECODE, MAX_DATA_BITS, ones);
		send_word(OP_DECODE, MAX_DATA_BITS, '0);
		drain();
		write_length(6'd5);

		// syndrome past the end of a short codeword, junk above the codeword
		send_word(OP_DECODE, 6'd5, (64'd1 << 0) | (64'd1 << 3) | (64'd1 << 9));
		enc = u_chk.hamming_result(OP_ENCODE, 6'd5, 64'h15, cur_len);
		send_word(OP_DECODE, 6'd5, enc.word | 64'hFFFF_FFFF_FFFF_FC00);
		send_word(OP_ENCODE, 6'd5, ones);
		send_word(OP_DECODE, 6'd3, enc.word ^ (64'd1 << 2));

		lens[0][0] = MAX_DATA_BITS;
		lens[0][1] = 6'd0;
		lens[0][2] = 6'd20;
		lens[1][0] = 6'd1;
		lens[1][1] = 6'd63;
		lens[1][2] = LEN_W'($urandom_range(63));
		lens[2][0] = MAX_DATA_BITS;
		lens[2][1] = 6'd8;
		lens[2][2] = LEN_W'($urandom_range(1, 57));

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle = 17;
					snk_idle = 65;
				end
				1: begin
					src_idle = 65;
					snk_idle = 17;
				end
				default: begin
					src_idle = 0;
					snk_idle = 0;
				end
			endcase
			for (int s = 0; s < 3; s++) begin
				drain();
				write_length(lens[ph][s]);
				if (s == 0 && ph != 1)
					hold_wanted++;
				lim = (cur_len == 0) ? 1 : ((cur_len > MAX_DATA_BITS) ? MAX_DATA_BITS : cur_len);
				repeat (45) begin
					sel = $urandom_range(99);
					if (sel < 60)
						vb = cur_len;
					else if (sel < 85)
						vb = LEN_W'($urandom_range(1, lim));
					else
						vb = LEN_W'($urandom_range(63));
					data = rand_word();
					if ($urandom_range(99) < 35) begin
						send_word(OP_ENCODE, vb, data);
					end else begin
						enc = u_chk.hamming_result(OP_ENCODE, vb, data, cur_len);
						n = enc.bits;
						w = enc.word;
						sel = $urandom_range(99);
						p1 = $urandom_range(n - 1);
						p2 = $urandom_range(n - 1);
						while (p2 == p1)
							p2 = $urandom_range(n - 1);
						if (sel >= 30)
							w[p1] = ~w[p1];
						if (sel >= 65)
							w[p2] = ~w[p2];
						if (sel >= 85)
							w[$urandom_range(n - 1)] ^= 1'b1;
						if (sel >= 93)
							w = rand_word();
						if ($urandom_range(3) == 0)
							w |= rand_word() & ~((64'd1 << n) - 64'd1);
						send_word(OP_DECODE, vb, w);
					end
				end
			end
		end

		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
